// ===== sv/dcpc_pkg.sv =====
// Package for the depth-to-colored-point-cloud block.
// Holds register codes and reset values, queue entry and config types.
// No dependencies.
`default_nettype none
package dcpc_pkg;

	localparam int COLOR_WIDTH_DEF  = 640;
	localparam int COLOR_HEIGHT_DEF = 480;
	localparam int DEPTH_WIDTH_DEF  = 640;
	localparam int DEPTH_HEIGHT_DEF = 480;

	localparam int NUM_REGS    = 8;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 4;
	localparam int MAX_DEPTH   = 10000;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		REG_DEPTH_FOCAL  = 3'd0,
		REG_DEPTH_CENTER = 3'd1,
		REG_COLOR_FOCAL  = 3'd2,
		REG_COLOR_CENTER = 3'd3,
		REG_ROT_ROW0     = 3'd4,
		REG_ROT_ROW1     = 3'd5,
		REG_ROT_ROW2     = 3'd6,
		REG_TRANSLATION  = 3'd7
	} reg_idx_t;

	localparam logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
		64'd4503599628419072, 64'd0, 64'd4503599628419072, 64'd0,
		64'd262144, 64'd549755813888, 64'd1152921504606846976, 64'd0
	};
	localparam logic [CFG_W-1:0] REG_MASK [NUM_REGS] = '{
		64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
		64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
		64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
		64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF
	};

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_DEPTH = 1'b1
	} kind_t;

	// One classified item waiting between front and back.
	typedef struct packed {
		kind_t       kind;
		logic [8:0]  row;
		logic [9:0]  col;
		logic [15:0] depth;
		logic [23:0] rgb;
	} item_t;

	// Decoded configuration; rotation entry k*3+m is row k, column m.
	typedef struct packed {
		logic [31:0]      dfx;
		logic [31:0]      dfy;
		logic [31:0]      dcx;
		logic [31:0]      dcy;
		logic [31:0]      cfx;
		logic [31:0]      cfy;
		logic [31:0]      ccx;
		logic [31:0]      ccy;
		logic [8:0][20:0] rot;
		logic [2:0][20:0] trans;
	} cfg_t;

endpackage
`default_nettype wire

// ===== sv/dcpc_if.sv =====
// Channel interfaces: pixel items in, colored points out.
// Valid/ready handshake with payload; no dependencies.
`default_nettype none
interface dcpc_pixel_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [8:0]  pixel_row;
	logic [9:0]  pixel_col;
	logic [15:0] depth_mm;
	logic [7:0]  load_red;
	logic [7:0]  load_green;
	logic [7:0]  load_blue;

	modport source (output valid, action, pixel_row, pixel_col, depth_mm,
		load_red, load_green, load_blue, input ready);
	modport sink (input valid, action, pixel_row, pixel_col, depth_mm,
		load_red, load_green, load_blue, output ready);
endinterface

interface dcpc_point_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] point_x;
	logic signed [23:0] point_y;
	logic [22:0]        point_z;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;

	modport source (output valid, point_x, point_y, point_z, red, green, blue,
		input ready);
	modport sink (input valid, point_x, point_y, point_z, red, green, blue,
		output ready);
endinterface
`default_nettype wire

// ===== sv/dcpc_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module dcpc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 307200,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/dcpc_fifo.sv =====
// Short queue of classified items between front and back.
// Depends on dcpc_pkg.
`default_nettype none
module dcpc_fifo #(
	parameter int DEPTH = dcpc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dcpc_pkg::item_t din,
	output logic            full,
	input  logic            pop,
	output dcpc_pkg::item_t dout,
	output logic            empty
);
	import dcpc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   count_q;

	assign full  = (count_q == (PW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== sv/dcpc_front.sv =====
// Front end: accept pixel transactions, drop those out of frame or out of depth range, queue the rest.
// Depends on dcpc_pkg and dcpc_if.
`default_nettype none
module dcpc_front #(
	parameter int COLOR_WIDTH  = dcpc_pkg::COLOR_WIDTH_DEF,
	parameter int COLOR_HEIGHT = dcpc_pkg::COLOR_HEIGHT_DEF,
	parameter int DEPTH_WIDTH  = dcpc_pkg::DEPTH_WIDTH_DEF,
	parameter int DEPTH_HEIGHT = dcpc_pkg::DEPTH_HEIGHT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	dcpc_pixel_if.sink      pixel,
	output logic            push,
	output dcpc_pkg::item_t entry,
	input  logic            full
);
	import dcpc_pkg::*;

	logic  v_q;
	item_t entry_q;
	logic  accept, keep;

	assign push        = v_q && !full;
	assign pixel.ready = !v_q || !full;
	assign accept      = pixel.valid && pixel.ready;
	assign entry       = entry_q;

	always_comb begin
		if (pixel.action == KIND_LOAD) begin
			keep = (pixel.pixel_row < COLOR_HEIGHT) && (pixel.pixel_col < COLOR_WIDTH);
		end else begin
			keep = (pixel.pixel_row < DEPTH_HEIGHT) && (pixel.pixel_col < DEPTH_WIDTH)
				&& (pixel.depth_mm != 16'd0) && (pixel.depth_mm <= 16'(MAX_DEPTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (accept) begin
			v_q <= keep;
		end else if (push) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q.kind  <= kind_t'(pixel.action);
			entry_q.row   <= pixel.pixel_row;
			entry_q.col   <= pixel.pixel_col;
			entry_q.depth <= pixel.depth_mm;
			entry_q.rgb   <= {pixel.load_red, pixel.load_green, pixel.load_blue};
		end
	end
endmodule
`default_nettype wire

// ===== sv/dcpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Quotient must fit QW bits; no dependencies.
`default_nettype none
module dcpc_div #(
	parameter int NW = 53,
	parameter int DW = 32,
	parameter int QW = 24,
	parameter int TW = 2
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] n_in,
	input  logic [DW-1:0] d_in,
	input  logic [TW-1:0] tag_in,
	output logic [QW-1:0] q_out,
	output logic [TW-1:0] tag_out
);
	localparam int CW = (DW + QW > NW) ? DW + QW : NW;

	logic [NW-1:0] rem_q [1:QW];
	logic [DW-1:0] den_q [1:QW];
	logic [QW-1:0] quo_q [1:QW];
	logic [TW-1:0] tag_q [1:QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int SH = QW - 1 - i;
		logic [NW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [TW-1:0] tag_s;
		logic [CW-1:0] dsh, diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in = n_in;
			assign den_in = d_in;
			assign quo_in = '0;
			assign tag_s  = tag_in;
		end else begin : g_next
			assign rem_in = rem_q[i];
			assign den_in = den_q[i];
			assign quo_in = quo_q[i];
			assign tag_s  = tag_q[i];
		end

		assign dsh  = CW'(den_in) << SH;
		assign ge   = CW'(rem_in) >= dsh;
		assign diff = CW'(rem_in) - dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1] <= ge ? diff[NW-1:0] : rem_in;
				den_q[i+1] <= den_in;
				quo_q[i+1] <= (quo_in << 1) | QW'(ge);
				tag_q[i+1] <= tag_s;
			end
		end
	end

	assign q_out   = quo_q[QW];
	assign tag_out = tag_q[QW];
endmodule
`default_nettype wire

// ===== sv/dcpc_back.sv =====
// Back end: back-projection, rigid transform, color projection, frame store access.
// Depends on dcpc_pkg, dcpc_if, dcpc_div and dcpc_ram.
`default_nettype none
module dcpc_back #(
	parameter int COLOR_WIDTH  = dcpc_pkg::COLOR_WIDTH_DEF,
	parameter int COLOR_HEIGHT = dcpc_pkg::COLOR_HEIGHT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dcpc_pkg::cfg_t  cfg,
	input  dcpc_pkg::item_t head,
	input  logic            head_valid,
	output logic            pop,
	dcpc_point_if.source    point
);
	import dcpc_pkg::*;

	localparam int NPIX = COLOR_WIDTH * COLOR_HEIGHT;
	localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
	localparam int UW   = (COLOR_WIDTH > 1) ? $clog2(COLOR_WIDTH) : 1;
	localparam int VW   = (COLOR_HEIGHT > 1) ? $clog2(COLOR_HEIGHT) : 1;
	localparam int XQ   = 24;
	localparam int UQ   = 13;
	localparam logic [UQ-1:0] UMAX = UQ'(COLOR_WIDTH - 1);
	localparam logic [UQ-1:0] VMAX = UQ'(COLOR_HEIGHT - 1);

	localparam int POS_S4  = 4;
	localparam int POS_S5  = POS_S4 + XQ + 1;
	localparam int POS_S13 = POS_S5 + 8;
	localparam int POS_S14 = POS_S13 + UQ + 1;
	localparam int POS_S15 = POS_S14 + 1;
	localparam int POS_S16 = POS_S15 + 1;

	typedef struct packed {
		logic negx;
		logic satx;
	} tagx_t;
	typedef struct packed {
		logic          negy;
		logic          saty;
		kind_t         kind;
		logic [19:0]   z0;
		logic [23:0]   rgb;
		logic [AW-1:0] addr;
	} tagy_t;
	typedef struct packed {
		logic negu;
		logic satu;
	} tagu_t;
	typedef struct packed {
		logic               negv;
		logic               satv;
		kind_t              kind;
		logic               keep;
		logic signed [23:0] ptx;
		logic signed [23:0] pty;
		logic [22:0]        ptz;
		logic [23:0]        rgb;
		logic [AW-1:0]      addr;
	} tagv_t;

	function automatic logic [23:0] x_sat(logic neg, logic sat, logic [23:0] q);
		logic [23:0] r;
		if (sat || q[23]) begin
			r = neg ? 24'h800000 : 24'h7FFFFF;
		end else begin
			r = neg ? (~q + 24'd1) : q;
		end
		return r;
	endfunction

	function automatic logic [23:0] clip24(logic signed [29:0] p);
		logic [23:0] r;
		if (p > 30'sd8388607) begin
			r = 24'h7FFFFF;
		end else if (p < -30'sd8388608) begin
			r = 24'h800000;
		end else begin
			r = p[23:0];
		end
		return r;
	endfunction

	logic          adv;
	logic [POS_S16:1] vld_q;
	logic          outv_q;

	// Whole back pipeline advances in lockstep; it stops only when the output holds.
	assign adv   = !outv_q || point.ready;
	assign pop   = adv && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[POS_S16-1:1], head_valid};
		end
	end

	// Zero depth focal lengths count as the smallest step.
	logic [31:0] fxe, fye;
	assign fxe = (cfg.dfx == 32'd0) ? 32'd1 : cfg.dfx;
	assign fye = (cfg.dfy == 32'd0) ? 32'd1 : cfg.dfy;

	// S1: centered pixel coordinates, z0, load address.
	kind_t              kind_s1;
	logic [23:0]        rgb_s1;
	logic [AW-1:0]      addr_s1;
	logic signed [33:0] nx_s1, ny_s1;
	logic [19:0]        z0_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= head.kind;
			rgb_s1  <= head.rgb;
			addr_s1 <= AW'(head.row) * AW'(COLOR_WIDTH) + AW'(head.col);
			nx_s1   <= $signed({4'b0, head.col, 20'b0}) - $signed({2'b0, cfg.dcx});
			ny_s1   <= $signed({5'b0, head.row, 20'b0}) - $signed({2'b0, cfg.dcy});
			z0_s1   <= {head.depth, 4'b0};
		end
	end

	// S2: scale by depth.
	kind_t              kind_s2;
	logic [23:0]        rgb_s2;
	logic [AW-1:0]      addr_s2;
	logic signed [54:0] px_s2, py_s2;
	logic [19:0]        z0_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			rgb_s2  <= rgb_s1;
			addr_s2 <= addr_s1;
			px_s2   <= nx_s1 * $signed({1'b0, z0_s1});
			py_s2   <= ny_s1 * $signed({1'b0, z0_s1});
			z0_s2   <= z0_s1;
		end
	end

	// S3: magnitude plus half divisor.
	logic [54:0]   absx, absy;
	kind_t         kind_s3;
	logic [23:0]   rgb_s3;
	logic [AW-1:0] addr_s3;
	logic [19:0]   z0_s3;
	logic          negx_s3, negy_s3;
	logic [52:0]   magx_s3, magy_s3;

	assign absx = px_s2[54] ? 55'(-px_s2) : 55'(px_s2);
	assign absy = py_s2[54] ? 55'(-py_s2) : 55'(py_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s3 <= kind_s2;
			rgb_s3  <= rgb_s2;
			addr_s3 <= addr_s2;
			z0_s3   <= z0_s2;
			negx_s3 <= px_s2[54];
			negy_s3 <= py_s2[54];
			magx_s3 <= absx[52:0] + {22'b0, fxe[31:1]};
			magy_s3 <= absy[52:0] + {22'b0, fye[31:1]};
		end
	end

	// S4: flag quotients that overflow 24 bits, then enter the dividers.
	tagx_t       tagx_s4;
	tagy_t       tagy_s4;
	logic [52:0] magx_s4, magy_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			magx_s4      <= magx_s3;
			magy_s4      <= magy_s3;
			tagx_s4.negx <= negx_s3;
			tagx_s4.satx <= {3'b0, magx_s3} >= {fxe, 24'b0};
			tagy_s4.negy <= negy_s3;
			tagy_s4.saty <= {3'b0, magy_s3} >= {fye, 24'b0};
			tagy_s4.kind <= kind_s3;
			tagy_s4.z0   <= z0_s3;
			tagy_s4.rgb  <= rgb_s3;
			tagy_s4.addr <= addr_s3;
		end
	end

	logic [XQ-1:0] qx, qy;
	tagx_t         tagx_d;
	tagy_t         tagy_d;

	dcpc_div #(.NW(53), .DW(32), .QW(XQ), .TW($bits(tagx_t))) u_div_x (
		.clk(clk), .en(adv), .n_in(magx_s4), .d_in(fxe), .tag_in(tagx_s4),
		.q_out(qx), .tag_out(tagx_d)
	);
	dcpc_div #(.NW(53), .DW(32), .QW(XQ), .TW($bits(tagy_t))) u_div_y (
		.clk(clk), .en(adv), .n_in(magy_s4), .d_in(fye), .tag_in(tagy_s4),
		.q_out(qy), .tag_out(tagy_d)
	);

	// S5: saturated back-projected point.
	kind_t              kind_s5;
	logic [23:0]        rgb_s5;
	logic [AW-1:0]      addr_s5;
	logic [19:0]        z0_s5;
	logic signed [23:0] x0_s5, y0_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s5 <= tagy_d.kind;
			rgb_s5  <= tagy_d.rgb;
			addr_s5 <= tagy_d.addr;
			z0_s5   <= tagy_d.z0;
			x0_s5   <= $signed(x_sat(tagx_d.negx, tagx_d.satx, qx));
			y0_s5   <= $signed(x_sat(tagy_d.negy, tagy_d.saty, qy));
		end
	end

	// S6: nine rotation products.
	kind_t              kind_s6;
	logic [23:0]        rgb_s6;
	logic [AW-1:0]      addr_s6;
	logic signed [44:0] prod_s6 [3][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s6 <= kind_s5;
			rgb_s6  <= rgb_s5;
			addr_s6 <= addr_s5;
			for (int k = 0; k < 3; k++) begin
				prod_s6[k][0] <= $signed(cfg.rot[k*3]) * x0_s5;
				prod_s6[k][1] <= $signed(cfg.rot[k*3+1]) * y0_s5;
				prod_s6[k][2] <= 45'($signed(cfg.rot[k*3+2]) * $signed({1'b0, z0_s5}));
			end
		end
	end

	// S7: row sums.
	kind_t              kind_s7;
	logic [23:0]        rgb_s7;
	logic [AW-1:0]      addr_s7;
	logic signed [46:0] sum_s7 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s7 <= kind_s6;
			rgb_s7  <= rgb_s6;
			addr_s7 <= addr_s6;
			for (int k = 0; k < 3; k++) begin
				sum_s7[k] <= 47'(prod_s6[k][0]) + 47'(prod_s6[k][1]) + 47'(prod_s6[k][2]);
			end
		end
	end

	// S8: magnitude plus half of 2^18.
	kind_t         kind_s8;
	logic [23:0]   rgb_s8;
	logic [AW-1:0] addr_s8;
	logic          neg_s8 [3];
	logic [46:0]   mag_s8 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s8 <= kind_s7;
			rgb_s8  <= rgb_s7;
			addr_s8 <= addr_s7;
			for (int k = 0; k < 3; k++) begin
				neg_s8[k] <= sum_s7[k][46];
				mag_s8[k] <= (sum_s7[k][46] ? 47'(-sum_s7[k]) : 47'(sum_s7[k]))
					+ 47'd131072;
			end
		end
	end

	// S9: restore sign and add translation.
	kind_t              kind_s9;
	logic [23:0]        rgb_s9;
	logic [AW-1:0]      addr_s9;
	logic signed [29:0] p_s9 [3];
	logic signed [29:0] rmag [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rmag[k] = $signed({1'b0, mag_s8[k][46:18]});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s9 <= kind_s8;
			rgb_s9  <= rgb_s8;
			addr_s9 <= addr_s8;
			for (int k = 0; k < 3; k++) begin
				p_s9[k] <= (neg_s8[k] ? -rmag[k] : rmag[k]) + 30'($signed(cfg.trans[k]));
			end
		end
	end

	// S10: drop points behind the camera; color projection products.
	kind_t              kind_s10;
	logic               keep_s10;
	logic [23:0]        rgb_s10;
	logic [AW-1:0]      addr_s10;
	logic [29:0]        pz_s10;
	logic signed [23:0] ptx_s10, pty_s10;
	logic [22:0]        ptz_s10;
	logic signed [62:0] mu_s10, mv_s10;
	logic signed [63:0] cu_s10, cv_s10;
	logic [29:0]        pz9;

	assign pz9 = p_s9[2][29:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s10 <= kind_s9;
			keep_s10 <= vld_q[POS_S13-4] && (kind_s9 == KIND_DEPTH) && (p_s9[2] > 30'sd0);
			rgb_s10  <= rgb_s9;
			addr_s10 <= addr_s9;
			pz_s10   <= pz9;
			ptx_s10  <= $signed(clip24(p_s9[0]));
			pty_s10  <= $signed(clip24(p_s9[1]));
			ptz_s10  <= (pz9 > 30'd8388607) ? 23'h7FFFFF : pz9[22:0];
			mu_s10   <= p_s9[0] * $signed({1'b0, cfg.cfx});
			mv_s10   <= p_s9[1] * $signed({1'b0, cfg.cfy});
			cu_s10   <= $signed({1'b0, cfg.ccx}) * $signed({1'b0, pz9});
			cv_s10   <= $signed({1'b0, cfg.ccy}) * $signed({1'b0, pz9});
		end
	end

	// S11: projection numerators.
	kind_t              kind_s11;
	logic               keep_s11;
	logic [23:0]        rgb_s11;
	logic [AW-1:0]      addr_s11;
	logic [29:0]        pz_s11;
	logic signed [23:0] ptx_s11, pty_s11;
	logic [22:0]        ptz_s11;
	logic signed [63:0] nu_s11, nv_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s11 <= kind_s10;
			keep_s11 <= keep_s10;
			rgb_s11  <= rgb_s10;
			addr_s11 <= addr_s10;
			pz_s11   <= pz_s10;
			ptx_s11  <= ptx_s10;
			pty_s11  <= pty_s10;
			ptz_s11  <= ptz_s10;
			nu_s11   <= 64'(mu_s10) + cu_s10;
			nv_s11   <= 64'(mv_s10) + cv_s10;
		end
	end

	// S12: add half the denominator, then drop the 2^20 factor of it.
	logic [63:0]        absu, absv, ru, rv;
	kind_t              kind_s12;
	logic               keep_s12;
	logic [23:0]        rgb_s12;
	logic [AW-1:0]      addr_s12;
	logic [29:0]        pz_s12;
	logic signed [23:0] ptx_s12, pty_s12;
	logic [22:0]        ptz_s12;
	logic               negu_s12, negv_s12;
	logic [43:0]        au_s12, av_s12;

	assign absu = nu_s11[63] ? 64'(-nu_s11) : 64'(nu_s11);
	assign absv = nv_s11[63] ? 64'(-nv_s11) : 64'(nv_s11);
	assign ru   = absu + {15'b0, pz_s11, 19'b0};
	assign rv   = absv + {15'b0, pz_s11, 19'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s12 <= kind_s11;
			keep_s12 <= keep_s11;
			rgb_s12  <= rgb_s11;
			addr_s12 <= addr_s11;
			pz_s12   <= pz_s11;
			ptx_s12  <= ptx_s11;
			pty_s12  <= pty_s11;
			ptz_s12  <= ptz_s11;
			negu_s12 <= nu_s11[63];
			negv_s12 <= nv_s11[63];
			au_s12   <= ru[63:20];
			av_s12   <= rv[63:20];
		end
	end

	// S13: flag quotients past the frame, enter the projection dividers.
	tagu_t       tagu_s13;
	tagv_t       tagv_s13;
	logic [43:0] au_s13, av_s13;
	logic [29:0] pz_s13;

	always_ff @(posedge clk) begin
		if (adv) begin
			au_s13        <= au_s12;
			av_s13        <= av_s12;
			pz_s13        <= pz_s12;
			tagu_s13.negu <= negu_s12;
			tagu_s13.satu <= au_s12 >= {1'b0, pz_s12, 13'b0};
			tagv_s13.negv <= negv_s12;
			tagv_s13.satv <= av_s12 >= {1'b0, pz_s12, 13'b0};
			tagv_s13.kind <= kind_s12;
			tagv_s13.keep <= keep_s12;
			tagv_s13.ptx  <= ptx_s12;
			tagv_s13.pty  <= pty_s12;
			tagv_s13.ptz  <= ptz_s12;
			tagv_s13.rgb  <= rgb_s12;
			tagv_s13.addr <= addr_s12;
		end
	end

	logic [UQ-1:0] qu, qv;
	tagu_t         tagu_d;
	tagv_t         tagv_d;

	dcpc_div #(.NW(44), .DW(30), .QW(UQ), .TW($bits(tagu_t))) u_div_u (
		.clk(clk), .en(adv), .n_in(au_s13), .d_in(pz_s13), .tag_in(tagu_s13),
		.q_out(qu), .tag_out(tagu_d)
	);
	dcpc_div #(.NW(44), .DW(30), .QW(UQ), .TW($bits(tagv_t))) u_div_v (
		.clk(clk), .en(adv), .n_in(av_s13), .d_in(pz_s13), .tag_in(tagv_s13),
		.q_out(qv), .tag_out(tagv_d)
	);

	// S14: clip to the frame.
	logic [UQ-1:0]      uc, vc;
	kind_t              kind_s14;
	logic               keep_s14;
	logic [23:0]        rgb_s14;
	logic [AW-1:0]      addr_s14;
	logic signed [23:0] ptx_s14, pty_s14;
	logic [22:0]        ptz_s14;
	logic [UW-1:0]      u_s14;
	logic [VW-1:0]      v_s14;

	always_comb begin
		if (tagu_d.negu) begin
			uc = '0;
		end else if (tagu_d.satu || (qu > UMAX)) begin
			uc = UMAX;
		end else begin
			uc = qu;
		end
		if (tagv_d.negv) begin
			vc = '0;
		end else if (tagv_d.satv || (qv > VMAX)) begin
			vc = VMAX;
		end else begin
			vc = qv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s14 <= tagv_d.kind;
			keep_s14 <= tagv_d.keep;
			rgb_s14  <= tagv_d.rgb;
			addr_s14 <= tagv_d.addr;
			ptx_s14  <= tagv_d.ptx;
			pty_s14  <= tagv_d.pty;
			ptz_s14  <= tagv_d.ptz;
			u_s14    <= uc[UW-1:0];
			v_s14    <= vc[VW-1:0];
		end
	end

	// S15: frame store address; loads write here, depth items read here.
	kind_t              kind_s15;
	logic               keep_s15;
	logic [23:0]        rgb_s15;
	logic [AW-1:0]      addr_s15;
	logic signed [23:0] ptx_s15, pty_s15;
	logic [22:0]        ptz_s15;
	logic [UW-1:0]      u_s15;
	logic [VW-1:0]      v_s15;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s15 <= kind_s14;
			keep_s15 <= keep_s14;
			rgb_s15  <= rgb_s14;
			addr_s15 <= (kind_s14 == KIND_LOAD) ? addr_s14
				: AW'(v_s14) * AW'(COLOR_WIDTH) + AW'(u_s14);
			ptx_s15  <= ptx_s14;
			pty_s15  <= pty_s14;
			ptz_s15  <= ptz_s14;
			u_s15    <= u_s14;
			v_s15    <= v_s14;
		end
	end

	logic [23:0] ram_rdata;

	dcpc_ram #(.WIDTH(24), .DEPTH(NPIX)) u_frame (
		.clk(clk), .en(adv && vld_q[POS_S15]), .we(kind_s15 == KIND_LOAD),
		.addr(addr_s15), .wdata(rgb_s15), .rdata(ram_rdata)
	);

	// S16: point waits beside the store read data.
	kind_t              kind_s16;
	logic               keep_s16;
	logic signed [23:0] ptx_s16, pty_s16;
	logic [22:0]        ptz_s16;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s16 <= kind_s15;
			keep_s16 <= keep_s15;
			ptx_s16  <= ptx_s15;
			pty_s16  <= pty_s15;
			ptz_s16  <= ptz_s15;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outv_q <= 1'b0;
		end else if (adv) begin
			outv_q <= vld_q[POS_S16] && keep_s16;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point.point_x <= ptx_s16;
			point.point_y <= pty_s16;
			point.point_z <= ptz_s16;
			point.red     <= ram_rdata[23:16];
			point.green   <= ram_rdata[15:8];
			point.blue    <= ram_rdata[7:0];
		end
	end

	assign point.valid = outv_q;

`ifndef NO_ASSERTIONS
	a_keep_depth: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[POS_S16] && keep_s16 |-> kind_s16 == KIND_DEPTH)
		else $error("load transaction marked for output");
	a_z_positive: assert property (@(posedge clk) disable iff (!arst_n)
		outv_q |-> point.point_z != 23'd0)
		else $error("point with non-positive z delivered");
	a_uv_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[POS_S15] && kind_s15 == KIND_DEPTH
			|-> (UQ'(u_s15) <= UMAX) && (UQ'(v_s15) <= VMAX))
		else $error("projected pixel outside color frame");
`endif
endmodule
`default_nettype wire

// ===== sv/depth_to_colored_point_cloud.sv =====
// Depth-to-colored-point-cloud top level: one item per cycle sustained while the output accepts.
// Pipeline: front register, queue, 16 arithmetic stages,
// 24 back-projection divider stages, 13 projection divider stages, output register.
// Throughput is set by the shared pipeline advancing one stage per cycle while the output does not hold.
// Reset clears control state and loads the register reset values; the color
// frame store is not cleared and is undefined until written.
`default_nettype none
module depth_to_colored_point_cloud #(
	parameter int COLOR_WIDTH  = dcpc_pkg::COLOR_WIDTH_DEF,
	parameter int COLOR_HEIGHT = dcpc_pkg::COLOR_HEIGHT_DEF,
	parameter int DEPTH_WIDTH  = dcpc_pkg::DEPTH_WIDTH_DEF,
	parameter int DEPTH_HEIGHT = dcpc_pkg::DEPTH_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dcpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dcpc_pkg::CFG_W-1:0]     cfg_data,
	dcpc_pixel_if.sink                     pixel,
	dcpc_point_if.source                   point
);
	import dcpc_pkg::*;

	// Configuration registers. Writes past the register list are dropped;
	// the 63-bit registers keep their top bit at zero.
	logic [CFG_W-1:0] reg_q [NUM_REGS];
	cfg_t             cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				reg_q[i] <= REG_RESET[i];
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
			reg_q[cfg_index[2:0]] <= cfg_data & REG_MASK[cfg_index[2:0]];
		end
	end

	// Split packed words into camera and transform fields.
	always_comb begin
		cfg.dfx = reg_q[REG_DEPTH_FOCAL][31:0];
		cfg.dfy = reg_q[REG_DEPTH_FOCAL][63:32];
		cfg.dcx = reg_q[REG_DEPTH_CENTER][31:0];
		cfg.dcy = reg_q[REG_DEPTH_CENTER][63:32];
		cfg.cfx = reg_q[REG_COLOR_FOCAL][31:0];
		cfg.cfy = reg_q[REG_COLOR_FOCAL][63:32];
		cfg.ccx = reg_q[REG_COLOR_CENTER][31:0];
		cfg.ccy = reg_q[REG_COLOR_CENTER][63:32];
		for (int m = 0; m < 3; m++) begin
			cfg.rot[m]     = reg_q[REG_ROT_ROW0][21*m +: 21];
			cfg.rot[3 + m] = reg_q[REG_ROT_ROW1][21*m +: 21];
			cfg.rot[6 + m] = reg_q[REG_ROT_ROW2][21*m +: 21];
			cfg.trans[m]   = reg_q[REG_TRANSLATION][21*m +: 21];
		end
	end

	// Front: accept each transaction, drop out-of-frame loads and depth samples
	// that are out of frame or out of depth range, and queue the rest in order.
	logic  push, full, pop, empty;
	item_t q_in, q_out;

	dcpc_front #(
		.COLOR_WIDTH(COLOR_WIDTH), .COLOR_HEIGHT(COLOR_HEIGHT),
		.DEPTH_WIDTH(DEPTH_WIDTH), .DEPTH_HEIGHT(DEPTH_HEIGHT)
	) u_front (
		.clk(clk), .arst_n(arst_n), .pixel(pixel),
		.push(push), .entry(q_in), .full(full)
	);

	// Queue: lets the front keep taking transactions while the back holds.
	dcpc_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .din(q_in), .full(full),
		.pop(pop), .dout(q_out), .empty(empty)
	);

	// Back: loads and depth items share one in-order pipeline so that every
	// store read sees exactly the loads that came before it.
	dcpc_back #(.COLOR_WIDTH(COLOR_WIDTH), .COLOR_HEIGHT(COLOR_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.head(q_out), .head_valid(!empty), .pop(pop), .point(point)
	);
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for depth_to_colored_point_cloud: loads color entries, then streams
// depth pixels under several camera settings and checks every colored point.
// Depends on dcpc_pkg and the dcpc_pixel_if / dcpc_point_if interfaces.
`timescale 1ns / 1ps
module tb_top;
	import dcpc_pkg::*;

	localparam int CW = COLOR_WIDTH_DEF;
	localparam int CH = COLOR_HEIGHT_DEF;
	localparam int DW = DEPTH_WIDTH_DEF;
	localparam int DH = DEPTH_HEIGHT_DEF;
	localparam int DRAIN_CYCLES = 100;         // above the pipeline latency
	localparam longint CYCLE_LIMIT = 4000000;
	localparam longint SAT_MAX = 8388607;
	localparam longint SAT_MIN = -8388608;

	typedef struct {
		logic [23:0] x;
		logic [23:0] y;
		logic [22:0] z;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
	} colored_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	dcpc_pixel_if pix ();
	dcpc_point_if pt ();

	depth_to_colored_point_cloud DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pix.sink),
		.point     (pt.source)
	);

	// Shadow copies of the camera registers and of the color frame.
	logic [63:0] cam_reg [NUM_REGS];
	logic [23:0] frame_rgb [CW*CH];
	bit          written [CW*CH];
	colored_point_t pending_points [$];

	int errors = 0;
	longint cycles = 0;
	bit quiet = 1'b0;       // while set, no idling on either side
	int out_stall = 0;

	always #6 clk = ~clk;

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// n / d rounded half away from zero, d > 0.
	function automatic longint round_div(input longint n, input longint d);
		longint mag;
		longint q;
		mag = (n < 0) ? -n : n;
		q = (mag + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint lo32(input logic [63:0] r);
		return longint'({32'b0, r[31:0]});
	endfunction

	function automatic longint hi32(input logic [63:0] r);
		return longint'({32'b0, r[63:32]});
	endfunction

	function automatic longint entry21(input logic [63:0] r, input int k);
		logic signed [20:0] f;
		f = r[21*k +: 21];
		return longint'(f);
	endfunction

	// Back-project, transform and project one depth pixel; found is 0 when
	// the pixel gives no point. idx is the color entry that the point reads.
	function automatic bit register_depth(input int row, input int col, input int d,
			output colored_point_t cp, output int idx);
		longint z0, x0, y0, fxd, fyd, s, den, u, v;
		longint p [3];
		logic [63:0] rr;
		logic [23:0] c;
		idx = 0;
		if (row >= DH || col >= DW) return 1'b0;
		if (d == 0 || d > MAX_DEPTH) return 1'b0;
		z0 = 16 * longint'(d);
		fxd = lo32(cam_reg[REG_DEPTH_FOCAL]);
		fyd = hi32(cam_reg[REG_DEPTH_FOCAL]);
		if (fxd == 0) fxd = 1;
		if (fyd == 0) fyd = 1;
		x0 = round_div((longint'(col) * 1048576 - lo32(cam_reg[REG_DEPTH_CENTER])) * z0, fxd);
		y0 = round_div((longint'(row) * 1048576 - hi32(cam_reg[REG_DEPTH_CENTER])) * z0, fyd);
		x0 = clip(x0, SAT_MIN, SAT_MAX);
		y0 = clip(y0, SAT_MIN, SAT_MAX);
		for (int k = 0; k < 3; k++) begin
			rr = cam_reg[REG_ROT_ROW0 + k];
			s = entry21(rr, 0) * x0 + entry21(rr, 1) * y0 + entry21(rr, 2) * z0;
			p[k] = round_div(s, 262144) + entry21(cam_reg[REG_TRANSLATION], k);
		end
		if (p[2] <= 0) return 1'b0;
		den = p[2] * 1048576;
		u = clip(round_div(p[0] * lo32(cam_reg[REG_COLOR_FOCAL])
			+ lo32(cam_reg[REG_COLOR_CENTER]) * p[2], den), 0, CW - 1);
		v = clip(round_div(p[1] * hi32(cam_reg[REG_COLOR_FOCAL])
			+ hi32(cam_reg[REG_COLOR_CENTER]) * p[2], den), 0, CH - 1);
		idx = int'(v * CW + u);
		c = frame_rgb[idx];
		cp.x = 24'(clip(p[0], SAT_MIN, SAT_MAX));
		cp.y = 24'(clip(p[1], SAT_MIN, SAT_MAX));
		cp.z = 23'(clip(p[2], 1, SAT_MAX));
		cp.r = c[23:16];
		cp.g = c[15:8];
		cp.b = c[7:0];
		return 1'b1;
	endfunction

	// Drive one pixel transaction; an optional idle burst comes first.
	task automatic send_pixel(input bit action, input int row, input int col, input int d,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		colored_point_t cp;
		int gap;
		int idx;
		gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid      <= 1'b1;
		pix.action     <= action;
		pix.pixel_row  <= 9'(row);
		pix.pixel_col  <= 10'(col);
		pix.depth_mm   <= 16'(d);
		pix.load_red   <= r;
		pix.load_green <= g;
		pix.load_blue  <= b;
		do @(posedge clk); while (!pix.ready);
		// Transaction accepted at this edge: advance the shadow model.
		if (action == KIND_LOAD) begin
			if (row < CH && col < CW) begin
				frame_rgb[row * CW + col] = {r, g, b};
				written[row * CW + col] = 1'b1;
			end
		end else if (register_depth(row, col, d, cp, idx)) begin
			pending_points = {pending_points, cp};
		end
	endtask

	// A point that lands on a never-loaded color entry gets that entry loaded first.
	task automatic send_depth(input int row, input int col, input int d);
		colored_point_t cp;
		int idx;
		if (register_depth(row, col, d, cp, idx) && !written[idx])
			send_pixel(KIND_LOAD, idx / CW, idx % CW, 0, $urandom, $urandom, $urandom);
		send_pixel(KIND_DEPTH, row, col, d, $urandom, $urandom, $urandom);
	endtask

	// Wait until the pipeline is empty, then write one register.
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		pix.valid <= 1'b0;
		do @(posedge clk); while (pending_points.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cam_reg[idx] = value & REG_MASK[idx];
	endtask

	function automatic logic [62:0] pack21(input longint a, input longint b, input longint c);
		return {21'(c), 21'(b), 21'(a)};
	endfunction

	// A plausible camera pair with random intrinsics and a near-identity pose.
	task automatic write_realistic_cameras();
		longint f, g;
		f = longint'($urandom_range(200, 1000)) << 20 | $urandom_range(0, 1048575);
		g = longint'($urandom_range(200, 1000)) << 20 | $urandom_range(0, 1048575);
		write_reg(REG_DEPTH_FOCAL, {32'(g), 32'(f)});
		write_reg(REG_DEPTH_CENTER, {32'($urandom_range(200, 280)) << 20,
			32'($urandom_range(280, 360)) << 20});
		f = longint'($urandom_range(200, 1000)) << 20;
		write_reg(REG_COLOR_FOCAL, {32'(f), 32'(f + $urandom_range(0, 99999))});
		write_reg(REG_COLOR_CENTER, {32'($urandom_range(0, 479)) << 20,
			32'($urandom_range(0, 639)) << 20});
		for (int k = 0; k < 3; k++)
			write_reg(reg_idx_t'(REG_ROT_ROW0 + k), {1'b0, pack21(
				(k == 0 ? 262144 : 0) + $urandom_range(0, 4000) - 2000,
				(k == 1 ? 262144 : 0) + $urandom_range(0, 4000) - 2000,
				(k == 2 ? 262144 : 0) + $urandom_range(0, 4000) - 2000)});
		write_reg(REG_TRANSLATION, {1'b0, pack21($urandom_range(0, 4000) - 2000,
			$urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000)});
	endtask

	// Load a block of color entries back to back.
	task automatic test_frame_fill();
		quiet = 1'b1;
		for (int i = 0; i < 8; i++)
			for (int j = 0; j < 8; j++)
				send_pixel(KIND_LOAD, i, j, $urandom, $urandom, $urandom, $urandom);
		quiet = 1'b0;
	endtask

	task automatic test_directed();
		// Reset cameras: unit focal lengths can saturate x and y.
		send_depth(0, 0, 1);
		send_depth(DH - 1, DW - 1, MAX_DEPTH);
		send_depth(240, 320, 0);
		send_depth(240, 320, MAX_DEPTH + 1);
		send_depth(240, 320, 65535);
		send_depth(DH, 10, 500);
		send_depth(511, 1023, 500);
		send_depth(10, DW, 500);
		send_pixel(KIND_LOAD, CH, 5, 0, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(KIND_LOAD, 7, 1023, 0, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(KIND_LOAD, 0, 0, 0, 8'hFF, 8'h00, 8'hAA);
		send_depth(0, 0, 1);
		write_realistic_cameras();
		send_depth(0, 0, 1);
		send_depth(DH - 1, DW - 1, MAX_DEPTH);
		send_depth(240, 320, 1234);
		// Zero depth focal lengths are taken as the smallest step.
		write_reg(REG_DEPTH_FOCAL, 64'd0);
		send_depth(100, 600, 9000);
		send_depth(479, 0, 3);
		// Push the scene behind the color camera.
		write_reg(REG_TRANSLATION, {1'b0, pack21(0, 0, -1048576)});
		send_depth(200, 200, 10);
		send_depth(200, 200, MAX_DEPTH);
		write_reg(REG_TRANSLATION, {1'b0, pack21(1048575, -1048576, 1048575)});
		send_depth(1, 2, 5000);
	endtask

	task automatic random_items(input int count);
		int sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 70)
				send_depth($urandom_range(0, DH - 1), $urandom_range(0, DW - 1),
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 50)
					: $urandom_range(1, MAX_DEPTH));
			else if (sel < 85)
				send_pixel(KIND_LOAD, $urandom_range(0, CH - 1), $urandom_range(0, CW - 1),
					$urandom, $urandom, $urandom, $urandom);
			else if (sel < 93)
				send_depth($urandom_range(0, 511), $urandom_range(0, 1023),
					$urandom_range(0, 65535));
			else
				send_pixel(KIND_LOAD, $urandom_range(0, 511), $urandom_range(0, 1023),
					$urandom_range(0, 65535), $urandom, $urandom, $urandom);
		end
	endtask

	// Register extremes: all zeros, all ones, then random values in every register.
	task automatic test_extremes();
		for (int k = 0; k < NUM_REGS; k++) write_reg(reg_idx_t'(k), '0);
		random_items(60);
		for (int k = 0; k < NUM_REGS; k++) write_reg(reg_idx_t'(k), '1);
		random_items(60);
		for (int k = 0; k < NUM_REGS; k++) write_reg(reg_idx_t'(k), {$urandom, $urandom});
		random_items(60);
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 6; ph++) begin
			write_realistic_cameras();
			if (ph == 5) quiet = 1'b1;
			random_items(120);
		end
	endtask

	// Output side: random stall bursts, and check each point transaction.
	always @(posedge clk) begin
		colored_point_t want;
		if (pt.valid && pt.ready) begin
			if (pending_points.size() == 0) begin
				report("unexpected point", pt.point_z, 0);
			end else begin
				want = pending_points.pop_front();
				if (pt.point_x !== want.x) report("point_x", $signed(pt.point_x), $signed(want.x));
				if (pt.point_y !== want.y) report("point_y", $signed(pt.point_y), $signed(want.y));
				if (pt.point_z !== want.z) report("point_z", pt.point_z, want.z);
				if (pt.red !== want.r) report("red", pt.red, want.r);
				if (pt.green !== want.g) report("green", pt.green, want.g);
				if (pt.blue !== want.b) report("blue", pt.blue, want.b);
			end
		end
		if (quiet) begin
			out_stall <= 0;
			pt.ready <= 1'b1;
		end else if (out_stall > 0) begin
			out_stall <= out_stall - 1;
			pt.ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			out_stall <= $urandom_range(0, 18);
			pt.ready <= 1'b0;
		end else begin
			pt.ready <= 1'b1;
		end
	end

	initial begin
		for (int k = 0; k < NUM_REGS; k++) cam_reg[k] = REG_RESET[k];
		pix.valid = 1'b0;
		pix.action = KIND_LOAD;
		pix.pixel_row = '0;
		pix.pixel_col = '0;
		pix.depth_mm = '0;
		pix.load_red = '0;
		pix.load_green = '0;
		pix.load_blue = '0;
		pt.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_frame_fill();
		test_directed();
		test_extremes();
		test_random();
		pix.valid <= 1'b0;
		// Drain: hold until all points arrived, then let the pipeline settle.
		while (pending_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
